>>> rtl/csl_pkg.sv
// csl_pkg: shared types, token codes and character class helpers for the lexer
// used by csl_step and c_subset_lexer; depends on nothing
package csl_pkg;

   localparam int POS_BITS_DEF = 32;
   localparam int LEN_BITS_DEF = 16;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FLOAT, M_OP,
      M_CH_OPEN, M_CH_ESC, M_CH_CLOSE, M_STRING
   } mode_type;

   localparam logic [3:0] K_KEYWORD = 4'd0;
   localparam logic [3:0] K_IDENT   = 4'd1;
   localparam logic [3:0] K_INT     = 4'd2;
   localparam logic [3:0] K_FLOAT   = 4'd3;
   localparam logic [3:0] K_CHAR    = 4'd4;
   localparam logic [3:0] K_STRING  = 4'd5;
   localparam logic [3:0] K_OP      = 4'd6;
   localparam logic [3:0] K_PUNCT   = 4'd7;
   localparam logic [3:0] K_ERROR   = 4'd8;
   localparam logic [3:0] K_END     = 4'd9;

   localparam logic [3:0] E_UNRECOGNISED = 4'd0;
   localparam logic [3:0] E_COMMA        = 4'd1;
   localparam logic [3:0] E_COMPOUND     = 4'd2;
   localparam logic [3:0] E_OPEN_CHAR    = 4'd3;
   localparam logic [3:0] E_OPEN_STRING  = 4'd4;
   localparam logic [3:0] E_EMPTY        = 4'd5;

   localparam logic [3:0] OP_ASSIGN   = 4'd5;
   localparam logic [3:0] OP_EQ       = 4'd9;
   localparam logic [3:0] CODE_NONE   = 4'd0;

   typedef struct packed {
      mode_type   mode;
      logic [3:0] held_op;
      logic       after_bs;
      logic       halted;
      logic       saw_byte;
   } lex_flags_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // {hit, index} into "+-*/%=!<>"
   function automatic logic [4:0] op_index(input logic [7:0] c);
      logic [4:0] r;
      case (c)
         "+": r = {1'b1, 4'd0};
         "-": r = {1'b1, 4'd1};
         "*": r = {1'b1, 4'd2};
         "/": r = {1'b1, 4'd3};
         "%": r = {1'b1, 4'd4};
         "=": r = {1'b1, 4'd5};
         "!": r = {1'b1, 4'd6};
         "<": r = {1'b1, 4'd7};
         ">": r = {1'b1, 4'd8};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // {hit, index} into "{}[]();"
   function automatic logic [4:0] punct_index(input logic [7:0] c);
      logic [4:0] r;
      case (c)
         "{": r = {1'b1, 4'd0};
         "}": r = {1'b1, 4'd1};
         "[": r = {1'b1, 4'd2};
         "]": r = {1'b1, 4'd3};
         "(": r = {1'b1, 4'd4};
         ")": r = {1'b1, 4'd5};
         ";": r = {1'b1, 4'd6};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // len is the word length clipped to 7
   function automatic logic [4:0] kw_match(input logic [47:0] p, input logic [2:0] len);
      logic [4:0] r;
      r = 5'd0;
      if (len == 3'd6 && p == 48'("return")) r = {1'b1, 4'd0};
      if (len == 3'd2 && p == 48'("if"))     r = {1'b1, 4'd1};
      if (len == 3'd4 && p == 48'("else"))   r = {1'b1, 4'd2};
      if (len == 3'd5 && p == 48'("while"))  r = {1'b1, 4'd3};
      if (len == 3'd3 && p == 48'("for"))    r = {1'b1, 4'd4};
      if (len == 3'd4 && p == 48'("void"))   r = {1'b1, 4'd5};
      if (len == 3'd3 && p == 48'("int"))    r = {1'b1, 4'd6};
      if (len == 3'd5 && p == 48'("float"))  r = {1'b1, 4'd7};
      if (len == 3'd4 && p == 48'("char"))   r = {1'b1, 4'd8};
      if (len == 3'd6 && p == 48'("static")) r = {1'b1, 4'd9};
      return r;
   endfunction

endpackage

>>> rtl/c_subset_lexer.sv
// c_subset_lexer: top level of the byte-stream tokenizer for a small C subset
// depends on csl_pkg and csl_step
//
// Usage: source bytes enter one per transaction on the req_ channel, req_tdata
// holding the byte and req_tlast marking the end of input (byte then ignored;
// a zero byte also ends the input). Token records leave on the rsp_ channel:
// kind, code, start offset and length in rsp_tdata, rsp_tlast on the last
// record caused by one input byte. A byte yields zero to three records.
// A byte is registered in the input register, its records in the group register
// when it advances. Throughput: one byte per cycle while each byte yields at most
// one record and the receiver is ready; a byte yielding more records holds the
// group register, which drains one record per cycle while rsp_tready is high.
// Reset clears all lexer state and drops any held byte or record. When the
// receiver stalls, the record register holds and one more byte is taken into
// the input register before req_tready falls.
module c_subset_lexer #(
   parameter int POS_BITS = csl_pkg::POS_BITS_DEF,
   parameter int LEN_BITS = csl_pkg::LEN_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // char_byte
   input  logic        req_tlast,  // is_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // token_kind[3:0], token_code[7:4], start_pos, token_len, zero fill
   output logic [((8+POS_BITS+LEN_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic        rsp_tlast   // last_of_run
);
   import csl_pkg::*;

   localparam int DATA_W = ((8 + POS_BITS + LEN_BITS + 7) / 8) * 8;

   logic                 in_valid_ff;
   logic [7:0]           in_char_ff;
   logic                 in_end_ff;

   lex_flags_type        flags_ff, flags_in;
   logic [POS_BITS-1:0]  tstart_ff, tstart_in, bpos_ff, bpos_in;
   logic [LEN_BITS-1:0]  rlen_ff, rlen_in;
   logic [47:0]          prefix_ff, prefix_in;

   logic [1:0]              rec_cnt;
   logic [2:0][3:0]         rec_kind, rec_code;
   logic [2:0][POS_BITS-1:0] rec_start;
   logic [2:0][LEN_BITS-1:0] rec_len;

   logic                     grp_valid_ff;
   logic [1:0]               grp_cnt_ff, grp_idx_ff;
   logic [2:0][3:0]          grp_kind_ff, grp_code_ff;
   logic [2:0][POS_BITS-1:0] grp_start_ff;
   logic [2:0][LEN_BITS-1:0] grp_len_ff;

   logic grp_last, advance;

   csl_step #(.POS_BITS(POS_BITS), .LEN_BITS(LEN_BITS)) u_step (
      .char_byte(in_char_ff), .is_end(in_end_ff), .flags(flags_ff),
      .token_start(tstart_ff), .byte_pos(bpos_ff), .run_length(rlen_ff),
      .word_prefix(prefix_ff), .flags_nx(flags_in), .token_start_nx(tstart_in),
      .byte_pos_nx(bpos_in), .run_length_nx(rlen_in), .word_prefix_nx(prefix_in),
      .rec_cnt(rec_cnt), .rec_kind(rec_kind), .rec_code(rec_code),
      .rec_start(rec_start), .rec_len(rec_len)
   );

   assign grp_last   = (grp_idx_ff == grp_cnt_ff - 2'd1);
   assign advance    = in_valid_ff && (!grp_valid_ff || (rsp_tready && grp_last));
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = grp_valid_ff;
   assign rsp_tlast  = grp_last;
   // zero fill up to whole bytes
   assign rsp_tdata  = DATA_W'({grp_len_ff[grp_idx_ff], grp_start_ff[grp_idx_ff],
                                grp_code_ff[grp_idx_ff], grp_kind_ff[grp_idx_ff]});

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         grp_valid_ff <= 1'b0;
         grp_cnt_ff   <= 2'd0;
         grp_idx_ff   <= 2'd0;
         flags_ff     <= '{mode: M_IDLE, held_op: 4'd0, after_bs: 1'b0, halted: 1'b0,
                           saw_byte: 1'b0};
         tstart_ff    <= '0;
         bpos_ff      <= '0;
         rlen_ff      <= '0;
         prefix_ff    <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
            in_char_ff  <= req_tdata;
            in_end_ff   <= req_tlast;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            flags_ff     <= flags_in;
            tstart_ff    <= tstart_in;
            bpos_ff      <= bpos_in;
            rlen_ff      <= rlen_in;
            prefix_ff    <= prefix_in;
            grp_valid_ff <= (rec_cnt != 2'd0);
            grp_cnt_ff   <= rec_cnt;
            grp_idx_ff   <= 2'd0;
            grp_kind_ff  <= rec_kind;
            grp_code_ff  <= rec_code;
            grp_start_ff <= rec_start;
            grp_len_ff   <= rec_len;
         end else if (grp_valid_ff && rsp_tready) begin
            if (grp_last) grp_valid_ff <= 1'b0;
            else grp_idx_ff <= grp_idx_ff + 2'd1;
         end
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (grp_idx_ff < grp_cnt_ff))
      else $error("record index beyond group count");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("record group cut short");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("input register overrun");

endmodule

>>> rtl/csl_step.sv
// csl_step: next-state and token record logic for one source byte
// depends on csl_pkg
module csl_step #(
   parameter int POS_BITS = csl_pkg::POS_BITS_DEF,
   parameter int LEN_BITS = csl_pkg::LEN_BITS_DEF
) (
   input  logic [7:0]                  char_byte,
   input  logic                        is_end,
   input  csl_pkg::lex_flags_type      flags,
   input  logic [POS_BITS-1:0]         token_start,
   input  logic [POS_BITS-1:0]         byte_pos,
   input  logic [LEN_BITS-1:0]         run_length,
   input  logic [47:0]                 word_prefix,
   output csl_pkg::lex_flags_type      flags_nx,
   output logic [POS_BITS-1:0]         token_start_nx,
   output logic [POS_BITS-1:0]         byte_pos_nx,
   output logic [LEN_BITS-1:0]         run_length_nx,
   output logic [47:0]                 word_prefix_nx,
   output logic [1:0]                  rec_cnt,
   output logic [2:0][3:0]             rec_kind,
   output logic [2:0][3:0]             rec_code,
   output logic [2:0][POS_BITS-1:0]    rec_start,
   output logic [2:0][LEN_BITS-1:0]    rec_len
);
   import csl_pkg::*;

   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

   logic [LEN_BITS-1:0] run_inc, run_inc2;
   logic [POS_BITS-1:0] pos_prev;
   logic [2:0]          len_clip;
   logic [4:0]          kw, opi, pci;

   assign run_inc  = (run_length == LEN_MAX) ? run_length : run_length + LEN_ONE;
   assign run_inc2 = (run_inc == LEN_MAX) ? run_inc : run_inc + LEN_ONE;
   assign pos_prev = byte_pos - POS_BITS'(1);
   assign len_clip = (run_length > LEN_BITS'(6)) ? 3'd7 : run_length[2:0];
   assign kw  = kw_match(word_prefix, len_clip);
   assign opi = op_index(char_byte);
   assign pci = punct_index(char_byte);

   always_comb begin
      logic [1:0] n;
      logic       do_idle;
      n = 2'd0;
      do_idle = 1'b0;
      flags_nx = flags;
      token_start_nx = token_start;
      byte_pos_nx = byte_pos;
      run_length_nx = run_length;
      word_prefix_nx = word_prefix;
      rec_kind = '0;
      rec_code = '0;
      rec_start = '0;
      rec_len = '0;

      if (!is_end && char_byte != 8'd0) begin
         flags_nx.saw_byte = 1'b1;
         byte_pos_nx = byte_pos + POS_BITS'(1);
         if (!flags.halted) begin
            case (flags.mode)
               M_IDENT: begin
                  if (is_alpha(char_byte) || is_digit(char_byte)) begin
                     if (run_length < LEN_BITS'(6))
                        word_prefix_nx = {word_prefix[39:0], char_byte};
                     run_length_nx = run_inc;
                  end else begin
                     rec_kind[n] = kw[4] ? K_KEYWORD : K_IDENT;
                     rec_code[n] = kw[4] ? kw[3:0] : CODE_NONE;
                     rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_INT: begin
                  if (is_digit(char_byte)) run_length_nx = run_inc;
                  else if (char_byte == ".") flags_nx.mode = M_INT_DOT;
                  else begin
                     rec_kind[n] = K_INT; rec_code[n] = CODE_NONE;
                     rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_INT_DOT: begin
                  if (is_digit(char_byte)) begin
                     run_length_nx = run_inc2;
                     flags_nx.mode = M_FLOAT;
                  end else begin
                     rec_kind[n] = K_INT; rec_code[n] = CODE_NONE;
                     rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
                     rec_kind[n] = K_ERROR; rec_code[n] = E_UNRECOGNISED;
                     rec_start[n] = pos_prev; rec_len[n] = LEN_ONE; n = n + 2'd1;
                     flags_nx.halted = 1'b1; flags_nx.mode = M_IDLE; flags_nx.held_op = '0;
                  end
               end
               M_FLOAT: begin
                  if (is_digit(char_byte)) run_length_nx = run_inc;
                  else begin
                     rec_kind[n] = K_FLOAT; rec_code[n] = CODE_NONE;
                     rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_OP: begin
                  if (char_byte == "=" && flags.held_op >= OP_ASSIGN) begin
                     run_length_nx = run_inc;
                     rec_kind[n] = K_OP;
                     rec_code[n] = (flags.held_op == OP_ASSIGN) ? OP_EQ
                                                               : flags.held_op + 4'd4;
                     rec_start[n] = token_start; rec_len[n] = run_inc; n = n + 2'd1;
                     flags_nx.mode = M_IDLE; flags_nx.held_op = '0;
                  end else if (char_byte == "=") begin
                     run_length_nx = run_inc;
                     rec_kind[n] = K_ERROR; rec_code[n] = E_COMPOUND;
                     rec_start[n] = token_start; rec_len[n] = run_inc; n = n + 2'd1;
                     flags_nx.halted = 1'b1; flags_nx.mode = M_IDLE; flags_nx.held_op = '0;
                  end else begin
                     rec_kind[n] = K_OP; rec_code[n] = flags.held_op;
                     rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
                     flags_nx.held_op = '0;
                     do_idle = 1'b1;
                  end
               end
               M_CH_OPEN: begin
                  run_length_nx = run_inc;
                  flags_nx.mode = (char_byte == "\\") ? M_CH_ESC : M_CH_CLOSE;
               end
               M_CH_ESC: begin
                  run_length_nx = run_inc;
                  flags_nx.mode = M_CH_CLOSE;
               end
               M_CH_CLOSE: begin
                  if (char_byte == "'") begin
                     run_length_nx = run_inc;
                     rec_kind[n] = K_CHAR; rec_code[n] = CODE_NONE;
                     rec_start[n] = token_start; rec_len[n] = run_inc; n = n + 2'd1;
                     flags_nx.mode = M_IDLE;
                  end else begin
                     rec_kind[n] = K_ERROR; rec_code[n] = E_OPEN_CHAR;
                     rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
                     flags_nx.halted = 1'b1; flags_nx.mode = M_IDLE; flags_nx.held_op = '0;
                  end
               end
               M_STRING: begin
                  run_length_nx = run_inc;
                  if (flags.after_bs) flags_nx.after_bs = 1'b0;
                  else if (char_byte == "\\") flags_nx.after_bs = 1'b1;
                  else if (char_byte == "\"") begin
                     rec_kind[n] = K_STRING; rec_code[n] = CODE_NONE;
                     rec_start[n] = token_start; rec_len[n] = run_inc; n = n + 2'd1;
                     flags_nx.mode = M_IDLE;
                  end
               end
               default: do_idle = 1'b1;
            endcase

            // byte that starts a new token or stands alone
            if (do_idle) begin
               flags_nx.mode = M_IDLE;
               if (is_space(char_byte)) begin
               end else if (is_alpha(char_byte)) begin
                  flags_nx.mode = M_IDENT; token_start_nx = byte_pos;
                  run_length_nx = LEN_ONE; word_prefix_nx = {40'd0, char_byte};
               end else if (is_digit(char_byte)) begin
                  flags_nx.mode = M_INT; token_start_nx = byte_pos; run_length_nx = LEN_ONE;
               end else if (pci[4]) begin
                  rec_kind[n] = K_PUNCT; rec_code[n] = pci[3:0];
                  rec_start[n] = byte_pos; rec_len[n] = LEN_ONE; n = n + 2'd1;
               end else if (char_byte == ",") begin
                  rec_kind[n] = K_ERROR; rec_code[n] = E_COMMA;
                  rec_start[n] = byte_pos; rec_len[n] = LEN_ONE; n = n + 2'd1;
                  flags_nx.halted = 1'b1; flags_nx.held_op = '0;
               end else if (opi[4]) begin
                  flags_nx.mode = M_OP; token_start_nx = byte_pos; run_length_nx = LEN_ONE;
                  flags_nx.held_op = opi[3:0];
               end else if (char_byte == "'") begin
                  flags_nx.mode = M_CH_OPEN; token_start_nx = byte_pos; run_length_nx = LEN_ONE;
               end else if (char_byte == "\"") begin
                  flags_nx.mode = M_STRING; token_start_nx = byte_pos; run_length_nx = LEN_ONE;
                  flags_nx.after_bs = 1'b0;
               end else begin
                  rec_kind[n] = K_ERROR; rec_code[n] = E_UNRECOGNISED;
                  rec_start[n] = byte_pos; rec_len[n] = LEN_ONE; n = n + 2'd1;
                  flags_nx.halted = 1'b1; flags_nx.held_op = '0;
               end
            end
         end
      end else begin
         // end of input: flush, report, then back to reset state
         if (!(flags.saw_byte || !is_end)) begin
            rec_kind[n] = K_ERROR; rec_code[n] = E_EMPTY;
            rec_start[n] = '0; rec_len[n] = '0; n = n + 2'd1;
         end else if (!flags.halted) begin
            case (flags.mode)
               M_IDENT: begin
                  rec_kind[n] = kw[4] ? K_KEYWORD : K_IDENT;
                  rec_code[n] = kw[4] ? kw[3:0] : CODE_NONE;
                  rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
               end
               M_INT: begin
                  rec_kind[n] = K_INT; rec_code[n] = CODE_NONE;
                  rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
               end
               M_INT_DOT: begin
                  rec_kind[n] = K_INT; rec_code[n] = CODE_NONE;
                  rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
                  rec_kind[n] = K_ERROR; rec_code[n] = E_UNRECOGNISED;
                  rec_start[n] = pos_prev; rec_len[n] = LEN_ONE; n = n + 2'd1;
               end
               M_FLOAT: begin
                  rec_kind[n] = K_FLOAT; rec_code[n] = CODE_NONE;
                  rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
               end
               M_OP: begin
                  rec_kind[n] = K_OP; rec_code[n] = flags.held_op;
                  rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
               end
               M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
                  rec_kind[n] = K_ERROR; rec_code[n] = E_OPEN_CHAR;
                  rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
               end
               M_STRING: begin
                  rec_kind[n] = K_ERROR; rec_code[n] = E_OPEN_STRING;
                  rec_start[n] = token_start; rec_len[n] = run_length; n = n + 2'd1;
               end
               default: begin
               end
            endcase
         end
         rec_kind[n] = K_END; rec_code[n] = CODE_NONE;
         rec_start[n] = byte_pos; rec_len[n] = '0; n = n + 2'd1;
         flags_nx = '{mode: M_IDLE, held_op: 4'd0, after_bs: 1'b0, halted: 1'b0,
                      saw_byte: 1'b0};
         token_start_nx = '0;
         byte_pos_nx = '0;
         run_length_nx = '0;
         word_prefix_nx = '0;
      end
      rec_cnt = n;
   end

endmodule
